// ===== rtl/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// Contiguous bitmap allocator package
// Shared constants, codes, beat payload types and the controller state type.
// ----------------------------------------------------------------------------
package cba_pkg;

   localparam int MEM_UNITS_DEF = 256;
   localparam int WORD_BITS     = 4;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_NEXT  = 2'd1;
   localparam logic [1:0] POL_BEST  = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_BAD_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [8:0] req_size;
      logic [7:0] free_addr;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] status;
      logic [7:0] alloc_addr;
      logic       memory_full;
   } rsp_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_MOD,
      FSM_RESP
   } fsm_type;

endpackage

// ===== rtl/contiguous_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Contiguous bitmap allocator
// Used/free bitmap in a word memory with first, next and best fit placement.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate scans the bitmap one memory
// word of four units per cycle (a next fit that finds nothing makes a second
// pass from word zero), then marks the run with one read-modify-write per word
// it covers. A free walks the words of its range the same way. Clear, a bad
// size or range and an unknown command go straight to the response. The bitmap
// reads as all free after reset and after a clear.
module contiguous_bitmap_allocator_unit #(
   parameter int MEM_UNITS = cba_pkg::MEM_UNITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cba_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);
   import cba_pkg::*;

   localparam int W     = WORD_BITS;
   localparam int WORDS = MEM_UNITS / W;
   localparam int WB    = $clog2(W);
   localparam int WIW   = $clog2(WORDS);
   localparam int UW    = WIW + WB;
   localparam int AW    = $clog2(MEM_UNITS + 1);
   localparam int CW    = (AW > 9) ? AW + 1 : 10;

   logic [W-1:0] mem [WORDS];
   logic [WORDS-1:0] vld_ff, vld_in;
   logic [W-1:0] rd_data_ff;
   logic rd_vld_ff;
   logic mem_we;
   logic [W-1:0] mem_wd;

   fsm_type state_ff, state_in;
   logic [1:0] pol_ff, pol_in;
   logic [UW-1:0] nfs_ff, nfs_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [WIW-1:0] rd_idx_ff, rd_idx_in, proc_idx_ff, proc_idx_in, last_ff, last_in;
   logic issue_done_ff, issue_done_in, pv_ff, pv_in, pass_ff, pass_in;
   logic alloc_ff, alloc_in, found_ff, found_in, stop_ff, stop_in;
   logic [AW-1:0] size_ff, size_in, len_ff, len_in, best_ff, best_in;
   logic [AW-1:0] start_ff, start_in, addr_ff, addr_in, lo_ff, lo_in, hi_ff, hi_in;
   logic res_ok_ff, res_ok_in;
   logic [1:0] res_st_ff, res_st_in;
   logic [7:0] res_addr_ff, res_addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [W-1:0] word, nword;
   logic [AW-1:0] c_len, c_start, c_best, c_addr, u;
   logic c_found, c_stop, used, is_best, is_next, in_rng;
   logic [WB:0] freed;
   logic req_fire;
   logic [CW-1:0] sz_x, end_x;
   int j;

   assign req_ready = (state_ff == FSM_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign is_best   = (pol_ff == POL_BEST);
   assign is_next   = (pol_ff == POL_NEXT);
   assign word      = rd_vld_ff ? rd_data_ff : '0;
   assign sz_x      = CW'(req_data.req_size);
   assign end_x     = CW'(req_data.free_addr) + CW'(req_data.req_size);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[proc_idx_ff] <= mem_wd;
      end
      rd_data_ff <= mem[rd_idx_ff];
      rd_vld_ff  <= vld_ff[rd_idx_ff];
   end

   // Per-word scan and modify logic.
   always_comb begin
      c_len   = len_ff;
      c_start = start_ff;
      c_best  = best_ff;
      c_addr  = addr_ff;
      c_found = found_ff;
      c_stop  = stop_ff;
      nword   = word;
      freed   = '0;
      used    = 1'b0;
      in_rng  = 1'b0;
      u       = '0;
      for (j = 0; j < W; j++) begin
         u = AW'({proc_idx_ff, WB'(j)});
         used = word[j] || (is_next && !pass_ff && (u < AW'(nfs_ff)));
         in_rng = (u >= lo_ff) && (u < hi_ff);
         if (is_best) begin
            if (used) begin
               if (c_len >= size_ff && (!c_found || c_len < c_best)) begin
                  c_found = 1'b1;
                  c_best  = c_len;
                  c_addr  = c_start;
               end
               c_len = '0;
            end else begin
               if (c_len == '0) begin
                  c_start = u;
               end
               c_len = c_len + 1'b1;
               if (u == AW'(MEM_UNITS - 1) && c_len >= size_ff &&
                   (!c_found || c_len < c_best)) begin
                  c_found = 1'b1;
                  c_best  = c_len;
                  c_addr  = c_start;
               end
            end
         end else if (!c_found) begin
            if (used) begin
               c_len = '0;
            end else begin
               if (c_len == '0) begin
                  c_start = u;
               end
               c_len = c_len + 1'b1;
               if (c_len >= size_ff) begin
                  c_found = 1'b1;
                  c_addr  = c_start;
               end
            end
         end
         if (alloc_ff) begin
            nword[j] = word[j] | in_rng;
         end else if (in_rng && !c_stop) begin
            if (word[j]) begin
               nword[j] = 1'b0;
               freed = freed + 1'b1;
            end else begin
               c_stop = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      pol_in        = csr_valid ? csr_data : pol_ff;
      nfs_in        = nfs_ff;
      cnt_in        = cnt_ff;
      vld_in        = vld_ff;
      rd_idx_in     = rd_idx_ff;
      proc_idx_in   = proc_idx_ff;
      last_in       = last_ff;
      issue_done_in = issue_done_ff;
      pv_in         = 1'b0;
      pass_in       = pass_ff;
      alloc_in      = alloc_ff;
      found_in      = found_ff;
      stop_in       = stop_ff;
      size_in       = size_ff;
      len_in        = len_ff;
      best_in       = best_ff;
      start_in      = start_ff;
      addr_in       = addr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      res_ok_in     = res_ok_ff;
      res_st_in     = res_st_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wd        = nword;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               res_ok_in   = 1'b0;
               res_st_in   = ST_BAD_RANGE;
               res_addr_in = '0;
               state_in    = FSM_RESP;
               len_in      = '0;
               found_in    = 1'b0;
               best_in     = '0;
               stop_in     = 1'b0;
               pass_in     = 1'b0;
               issue_done_in = 1'b0;
               size_in     = AW'(req_data.req_size);
               unique case (req_data.command)
                  CMD_ALLOC: begin
                     alloc_in = 1'b1;
                     if (sz_x != '0 && sz_x <= CW'(MEM_UNITS)) begin
                        state_in  = FSM_SCAN;
                        rd_idx_in = (pol_ff == POL_NEXT) ? nfs_ff[UW-1:WB] : '0;
                     end
                  end
                  CMD_FREE: begin
                     alloc_in = 1'b0;
                     if (sz_x != '0 && end_x <= CW'(MEM_UNITS)) begin
                        state_in  = FSM_MOD;
                        lo_in     = AW'(req_data.free_addr);
                        hi_in     = AW'(end_x);
                        rd_idx_in = WIW'(req_data.free_addr >> WB);
                        last_in   = WIW'((end_x - 1'b1) >> WB);
                     end
                  end
                  CMD_CLEAR: begin
                     vld_in    = '0;
                     cnt_in    = '0;
                     nfs_in    = '0;
                     res_ok_in = 1'b1;
                     res_st_in = ST_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            pv_in         = !issue_done_ff;
            proc_idx_in   = rd_idx_ff;
            rd_idx_in     = rd_idx_ff + 1'b1;
            issue_done_in = issue_done_ff || (rd_idx_ff == WIW'(WORDS - 1));
            if (pv_ff) begin
               len_in   = c_len;
               start_in = c_start;
               best_in  = c_best;
               addr_in  = c_addr;
               found_in = c_found;
               if ((c_found && !is_best) || proc_idx_ff == WIW'(WORDS - 1)) begin
                  pv_in = 1'b0;
                  if (c_found) begin
                     state_in  = FSM_MOD;
                     lo_in     = c_addr;
                     hi_in     = c_addr + size_ff;
                     last_in   = WIW'((c_addr + size_ff - 1'b1) >> WB);
                     rd_idx_in = WIW'(c_addr >> WB);
                  end else if (is_next && !pass_ff) begin
                     pass_in       = 1'b1;
                     len_in        = '0;
                     rd_idx_in     = '0;
                     issue_done_in = 1'b0;
                  end else begin
                     res_st_in = ST_NO_FIT;
                     state_in  = FSM_RESP;
                  end
               end
            end
         end
         FSM_MOD: begin
            pv_in       = 1'b1;
            proc_idx_in = rd_idx_ff;
            rd_idx_in   = rd_idx_ff + 1'b1;
            if (pv_ff) begin
               mem_we = 1'b1;
               vld_in[proc_idx_ff] = 1'b1;
               stop_in = c_stop;
               if (!alloc_ff) begin
                  cnt_in = cnt_ff - AW'(freed);
               end
               if (c_stop || proc_idx_ff == last_ff) begin
                  pv_in     = 1'b0;
                  state_in  = FSM_RESP;
                  res_ok_in = 1'b1;
                  res_st_in = ST_DONE;
                  if (alloc_ff) begin
                     cnt_in      = cnt_ff + size_ff;
                     nfs_in      = UW'(lo_ff);
                     res_addr_in = 8'(lo_ff);
                  end
               end
            end
         end
         FSM_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = res_ok_ff;
               rsp_in.status      = res_st_ff;
               rsp_in.alloc_addr  = res_addr_ff;
               rsp_in.memory_full = (cnt_ff == AW'(MEM_UNITS));
               state_in           = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         pol_ff       <= POL_FIRST;
         nfs_ff       <= '0;
         cnt_ff       <= '0;
         vld_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pol_ff       <= pol_in;
         nfs_ff       <= nfs_in;
         cnt_ff       <= cnt_in;
         vld_ff       <= vld_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      proc_idx_ff   <= proc_idx_in;
      last_ff       <= last_in;
      issue_done_ff <= issue_done_in;
      pass_ff       <= pass_in;
      alloc_ff      <= alloc_in;
      found_ff      <= found_in;
      stop_ff       <= stop_in;
      size_ff       <= size_in;
      len_ff        <= len_in;
      best_ff       <= best_in;
      start_ff      <= start_in;
      addr_ff       <= addr_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      res_ok_ff     <= res_ok_in;
      res_st_ff     <= res_st_in;
      res_addr_ff   <= res_addr_in;
      rsp_ff        <= rsp_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= AW'(MEM_UNITS)) else $error("used count exceeds memory size");
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ok == (rsp_data.status == ST_DONE)))
      else $error("ok and status disagree");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready) else $error("request taken while busy");
`endif

endmodule

// ===== sim/cba_checker.sv =====
// ----------------------------------------------------------------------------
// Contiguous bitmap allocator checker
// Watches the request, response and register channels, keeps its own copy of
// the bitmap and placement policy, and compares every response beat.
// ----------------------------------------------------------------------------
module cba_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cba_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cba_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_data,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_seen
);
   import cba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNITS = MEM_UNITS_DEF;

   logic [UNITS-1:0] used_map;
   logic [7:0]       next_start;
   logic [1:0]       policy;
   rsp_type          expected_rsp_q[$];

   function automatic int run_len(int at);
      int n;
      n = 0;
      while (at < UNITS && !used_map[at]) begin
         n++;
         at++;
      end
      return n;
   endfunction

   function automatic bit search_first(int from, int size, output int addr);
      int i;
      int len;
      i = from;
      addr = 0;
      while (i < UNITS) begin
         if (used_map[i]) begin
            i++;
         end else begin
            len = run_len(i);
            if (len >= size) begin
               addr = i;
               return 1'b1;
            end
            i += len;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit search_best(int size, output int addr);
      int  i;
      int  len;
      int  best;
      bit  found;
      i = 0;
      best = 0;
      found = 1'b0;
      addr = 0;
      while (i < UNITS) begin
         if (used_map[i]) begin
            i++;
         end else begin
            len = run_len(i);
            if (len >= size && (!found || len < best)) begin
               found = 1'b1;
               best = len;
               addr = i;
            end
            i += len;
         end
      end
      return found;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type o;
      int      size;
      int      faddr;
      int      addr;
      bit      found;
      int      i;
      size = r.req_size;
      faddr = r.free_addr;
      o = '0;
      o.status = ST_BAD_RANGE;
      if (r.command == CMD_ALLOC) begin
         if (size != 0 && size <= UNITS) begin
            if (policy == POL_BEST) begin
               found = search_best(size, addr);
            end else if (policy == POL_NEXT) begin
               found = search_first(next_start, size, addr);
               if (!found) found = search_first(0, size, addr);
            end else begin
               found = search_first(0, size, addr);
            end
            if (found) begin
               for (i = addr; i < addr + size && i < UNITS; i++) used_map[i] = 1'b1;
               next_start = addr[7:0];
               o.ok = 1'b1;
               o.status = ST_DONE;
               o.alloc_addr = addr[7:0];
            end else begin
               o.status = ST_NO_FIT;
            end
         end
      end else if (r.command == CMD_FREE) begin
         if (size != 0 && faddr + size <= UNITS) begin
            i = faddr;
            while (i < faddr + size && used_map[i]) begin
               used_map[i] = 1'b0;
               i++;
            end
            o.ok = 1'b1;
            o.status = ST_DONE;
         end
      end else if (r.command == CMD_CLEAR) begin
         used_map = '0;
         next_start = '0;
         o.ok = 1'b1;
         o.status = ST_DONE;
      end
      o.memory_full = &used_map;
      return o;
   endfunction

   assign pending_count = expected_rsp_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         used_map <= '0;
         next_start <= '0;
         policy <= POL_FIRST;
         expected_rsp_q.delete();
         fail_count <= 0;
         rsp_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) policy = csr_data;
         if (req_valid && req_ready) expected_rsp_q.push_back(apply_request(req_data));
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsp_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response beat %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want.ok !== rsp_data.ok || want.status !== rsp_data.status ||
                   want.alloc_addr !== rsp_data.alloc_addr ||
                   want.memory_full !== rsp_data.memory_full) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Contiguous bitmap allocator testbench
// Drives directed and random allocate, free and clear beats under all
// placement policies with random idling and back-pressure; a checker module
// predicts and compares every response beat.
// ----------------------------------------------------------------------------
module testbench;
   import cba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data = '0;
   int         fail_count;
   int         pending_count;
   int         rsp_seen;
   int         sent = 0;
   bit         calm = 1'b0;
   bit         hold_rsp = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   contiguous_bitmap_allocator_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   cba_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_seen(rsp_seen)
   );

   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 33);
      end
   end

   task automatic send_beat(logic [1:0] cmd, logic [8:0] size, logic [7:0] addr);
      while (!calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{command: cmd, req_size: size, free_addr: addr};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_policy(logic [1:0] pol);
      drain_all();
      csr_valid <= 1'b1;
      csr_data <= pol;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_beat();
      int k;
      k = $urandom_range(99);
      if (k < 55) begin
         send_beat(CMD_ALLOC, ($urandom_range(9) == 0) ? 9'($urandom_range(511))
                   : 9'($urandom_range(1, 24)), 8'($urandom));
      end else if (k < 90) begin
         send_beat(CMD_FREE, ($urandom_range(9) == 0) ? 9'($urandom_range(511))
                   : 9'($urandom_range(1, 30)), 8'($urandom));
      end else if (k < 95) begin
         send_beat(CMD_CLEAR, 9'($urandom), 8'($urandom));
      end else begin
         send_beat(2'd3, 9'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, bad sizes and ranges, each command.
      send_beat(CMD_ALLOC, 9'd0, 8'd0);
      send_beat(CMD_ALLOC, 9'd257, 8'd0);
      send_beat(CMD_ALLOC, 9'd511, 8'hFF);
      send_beat(CMD_ALLOC, 9'd256, 8'd0);
      send_beat(CMD_ALLOC, 9'd1, 8'd0);
      send_beat(CMD_FREE, 9'd0, 8'd0);
      send_beat(CMD_FREE, 9'd2, 8'd255);
      send_beat(CMD_FREE, 9'd1, 8'd255);
      send_beat(CMD_FREE, 9'd256, 8'd0);
      send_beat(CMD_FREE, 9'd4, 8'd10);
      send_beat(2'd3, 9'h1FF, 8'hFF);
      send_beat(CMD_CLEAR, 9'd0, 8'd0);
      send_beat(CMD_ALLOC, 9'd10, 8'd0);
      send_beat(CMD_ALLOC, 9'd5, 8'd0);
      send_beat(CMD_FREE, 9'd10, 8'd0);
      send_beat(CMD_ALLOC, 9'd3, 8'd0);
      send_beat(CMD_ALLOC, 9'd241, 8'd0);
      send_beat(CMD_ALLOC, 9'd242, 8'd0);
      send_beat(CMD_FREE, 9'd256, 8'd0);
      send_beat(CMD_CLEAR, 9'h1FF, 8'hFF);
      for (int p = 0; p < 4; p++) begin
         write_policy(2'(p));
         calm = (p == 1);
         for (int n = 0; n < 170; n++) begin
            if (p == 2 && n == 40) begin
               fork
                  begin
                     hold_rsp = 1'b1;
                     repeat (800) @(posedge clock);
                     hold_rsp = 1'b0;
                  end
               join_none
            end
            if (n == 100) drain_all();
            random_beat();
         end
      end
      calm = 1'b0;
      write_policy(POL_BEST);
      for (int n = 0; n < 40; n++) random_beat();
      drain_all();
      $display("Ran %0d request beats, %0d responses, under first, next, best fit", sent,
               rsp_seen);
      $display("and the spare policy code, with idling and a long response stall.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("[contiguous_bitmap_allocator_unit] OK");
      end else begin
         $display("[contiguous_bitmap_allocator_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("[contiguous_bitmap_allocator_unit] ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/cba_pkg.sv
rtl/contiguous_bitmap_allocator_unit.sv
sim/cba_checker.sv
sim/testbench.sv
